// File: hw/rtl/hpe_pkg.sv
// ----------------------------------------------------------------------------
// hpe_pkg
// Shared widths, constants and stage payload types of the Horner polynomial
// evaluator.
// ----------------------------------------------------------------------------
package hpe_pkg;

    // Number format and polynomial size.
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_COEFFS = 8;

    // Coefficient register file.
    localparam int REG_COUNT   = 8;
    localparam int COEFF_IDX_W = $clog2(REG_COUNT);
    localparam int CFG_IDX_W   = COEFF_IDX_W + 1;

    // The highest coefficient is loaded directly. Each remaining coefficient
    // costs one multiply stage and one round/add/saturate stage.
    localparam int NUM_STEPS = NUM_COEFFS - 1;
    localparam int MUL_N     = (NUM_STEPS > 0) ? NUM_STEPS : 1;

    // Saturation limits.
    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef logic [DATA_W-1:0] word_t;
    typedef logic [REG_COUNT-1:0][DATA_W-1:0] coeff_arr_t;

    // Payload between a round/add stage and the next multiply stage.
    typedef struct packed {
        word_t x;
        word_t acc;
        logic  sat;
    } acc_stage_t;

    // Payload between a multiply stage and its round/add stage.
    typedef struct packed {
        word_t             x;
        logic [PROD_W-1:0] prod;
        logic              sat;
    } mul_stage_t;

endpackage

// File: hw/rtl/hpe_arg_if.sv
// ----------------------------------------------------------------------------
// hpe_arg_if
// Argument stream: one polynomial argument per transaction.
// ----------------------------------------------------------------------------
interface hpe_arg_if;

    logic               valid;
    logic               ready;
    hpe_pkg::word_t     x_value;

    modport source (output valid, output x_value, input ready);
    modport sink   (input valid, input x_value, output ready);

endinterface

// File: hw/rtl/hpe_res_if.sv
// ----------------------------------------------------------------------------
// hpe_res_if
// Result stream: polynomial value and saturation flag per transaction.
// ----------------------------------------------------------------------------
interface hpe_res_if;

    logic               valid;
    logic               ready;
    hpe_pkg::word_t     poly_value;
    logic               saturated;

    modport source (output valid, output poly_value, output saturated, input ready);
    modport sink   (input valid, input poly_value, input saturated, output ready);

endinterface

// File: hw/rtl/hpe_cfg_if.sv
// ----------------------------------------------------------------------------
// hpe_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface hpe_cfg_if;

    logic                            valid;
    logic                            ready;
    logic [hpe_pkg::CFG_IDX_W-1:0]   index;
    hpe_pkg::word_t                  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

// File: hw/rtl/hpe_coeff_regs.sv
// ----------------------------------------------------------------------------
// hpe_coeff_regs
// Coefficient register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module hpe_coeff_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    hpe_cfg_if.sink              cfg,
    output hpe_pkg::coeff_arr_t  coeff
);

    hpe_pkg::coeff_arr_t coeff_reg;
    hpe_pkg::coeff_arr_t coeff_next;
    logic                idx_in_range;

    // Writes are always taken; indexes past the register file are dropped.
    assign cfg.ready    = 1'b1;
    assign idx_in_range = cfg.index < hpe_pkg::CFG_IDX_W'(hpe_pkg::REG_COUNT);

    always_comb
    begin
        coeff_next = coeff_reg;
        if (cfg.valid && idx_in_range)
        begin
            coeff_next[cfg.index[hpe_pkg::COEFF_IDX_W-1:0]] = cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= '0;
        end
        else
        begin
            coeff_reg <= coeff_next;
        end
    end

    assign coeff = coeff_reg;

endmodule

// File: hw/rtl/hpe_mul_stage.sv
// ----------------------------------------------------------------------------
// hpe_mul_stage
// Pipeline stage that forms the full signed product of accumulator and
// argument.
// ----------------------------------------------------------------------------
module hpe_mul_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  hpe_pkg::acc_stage_t  up_data,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output hpe_pkg::mul_stage_t  dn_data
);

    logic                valid_reg;
    logic                valid_next;
    hpe_pkg::mul_stage_t data_reg;
    hpe_pkg::mul_stage_t data_next;
    logic                load;

    // The stage takes new data when it is empty or its content moves on.
    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    always_comb
    begin
        valid_next = up_ready ? up_valid : valid_reg;
        data_next.x    = up_data.x;
        data_next.sat  = up_data.sat;
        data_next.prod = hpe_pkg::PROD_W'($signed(up_data.acc) * $signed(up_data.x));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload carries no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// File: hw/rtl/hpe_acc_stage.sv
// ----------------------------------------------------------------------------
// hpe_acc_stage
// Pipeline stage that rounds the product, adds one coefficient and
// saturates the new accumulator to 32 bits.
// ----------------------------------------------------------------------------
module hpe_acc_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hpe_pkg::word_t       coeff,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  hpe_pkg::mul_stage_t  up_data,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output hpe_pkg::acc_stage_t  dn_data
);

    logic                        valid_reg;
    logic                        valid_next;
    hpe_pkg::acc_stage_t         data_reg;
    hpe_pkg::acc_stage_t         data_next;
    logic                        load;
    logic                        rnd;
    logic [hpe_pkg::PROD_W-1:0]  shifted;
    logic [hpe_pkg::PROD_W-1:0]  sum;
    logic                        ovf;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    // Round to nearest, ties up: adding half an LSB before the floor shift
    // equals adding the highest dropped bit after it.
    generate
        if (hpe_pkg::FRAC_BITS > 0)
        begin : g_rnd
            assign rnd = up_data.prod[hpe_pkg::FRAC_BITS-1];
        end
        else
        begin : g_nornd
            assign rnd = 1'b0;
        end
    endgenerate

    assign shifted = $signed(up_data.prod) >>> hpe_pkg::FRAC_BITS;
    assign sum     = shifted + hpe_pkg::PROD_W'($signed(coeff))
                     + {{(hpe_pkg::PROD_W-1){1'b0}}, rnd};

    // Overflow when the bits above the 32-bit result are not all sign copies.
    assign ovf = !((&sum[hpe_pkg::PROD_W-1:hpe_pkg::DATA_W-1])
                   || (~|sum[hpe_pkg::PROD_W-1:hpe_pkg::DATA_W-1]));

    always_comb
    begin
        valid_next  = up_ready ? up_valid : valid_reg;
        data_next.x = up_data.x;
        data_next.sat = up_data.sat || ovf;
        if (ovf)
        begin
            data_next.acc = sum[hpe_pkg::PROD_W-1] ? hpe_pkg::SAT_MIN : hpe_pkg::SAT_MAX;
        end
        else
        begin
            data_next.acc = sum[hpe_pkg::DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload carries no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// File: hw/rtl/horner_polynomial_eval.sv
// Pipeline: 15 register stages: one load stage, then a multiply stage and a
// round/add/saturate stage for each of the seven lower coefficients.
// Throughput: one argument per cycle; each stage holds under backpressure.
// Reset: rst_n clears all stage valid bits and sets every coefficient to 0.
// ----------------------------------------------------------------------------
// horner_polynomial_eval
// Evaluates a degree-7 polynomial in signed Q16.16 by Horner's rule as a
// fully pipelined chain of multiply and round/add/saturate stages.
// ----------------------------------------------------------------------------
module horner_polynomial_eval (
    input  logic        clk,
    input  logic        rst_n,
    hpe_arg_if.sink     arg,
    hpe_res_if.source   result,
    hpe_cfg_if.sink     cfg
);

    hpe_pkg::coeff_arr_t coeff;

    // Round/add stage outputs; index 0 is the load stage.
    logic                stage_valid [0:hpe_pkg::NUM_STEPS];
    logic                stage_ready [0:hpe_pkg::NUM_STEPS];
    hpe_pkg::acc_stage_t stage_data  [0:hpe_pkg::NUM_STEPS];

    // Multiply stage outputs.
    logic                mul_valid [0:hpe_pkg::MUL_N-1];
    logic                mul_ready [0:hpe_pkg::MUL_N-1];
    hpe_pkg::mul_stage_t mul_data  [0:hpe_pkg::MUL_N-1];

    logic                load_valid_reg;
    logic                load_valid_next;
    hpe_pkg::acc_stage_t load_data_reg;
    hpe_pkg::acc_stage_t load_data_next;
    logic                load_en;

    hpe_coeff_regs u_coeff_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .coeff (coeff)
    );

    // Load stage: the first Horner step reduces to the top coefficient.
    assign arg.ready = !load_valid_reg || stage_ready[0];
    assign load_en   = arg.valid && arg.ready;

    always_comb
    begin
        load_valid_next    = arg.ready ? arg.valid : load_valid_reg;
        load_data_next.x   = arg.x_value;
        load_data_next.acc = coeff[hpe_pkg::NUM_COEFFS-1];
        load_data_next.sat = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_valid_reg <= 1'b0;
        end
        else
        begin
            load_valid_reg <= load_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            load_data_reg <= load_data_next;
        end
    end

    assign stage_valid[0] = load_valid_reg;
    assign stage_data[0]  = load_data_reg;

    // One multiply stage and one round/add stage per remaining coefficient.
    generate
        for (genvar k = 1; k <= hpe_pkg::NUM_STEPS; k++)
        begin : g_step
            hpe_mul_stage u_mul (
                .clk      (clk),
                .rst_n    (rst_n),
                .up_valid (stage_valid[k-1]),
                .up_ready (stage_ready[k-1]),
                .up_data  (stage_data[k-1]),
                .dn_valid (mul_valid[k-1]),
                .dn_ready (mul_ready[k-1]),
                .dn_data  (mul_data[k-1])
            );

            hpe_acc_stage u_acc (
                .clk      (clk),
                .rst_n    (rst_n),
                .coeff    (coeff[hpe_pkg::NUM_COEFFS-1-k]),
                .up_valid (mul_valid[k-1]),
                .up_ready (mul_ready[k-1]),
                .up_data  (mul_data[k-1]),
                .dn_valid (stage_valid[k]),
                .dn_ready (stage_ready[k]),
                .dn_data  (stage_data[k])
            );
        end
    endgenerate

    // The last stage register is the output register.
    assign stage_ready[hpe_pkg::NUM_STEPS] = result.ready;
    assign result.valid      = stage_valid[hpe_pkg::NUM_STEPS];
    assign result.poly_value = stage_data[hpe_pkg::NUM_STEPS].acc;
    assign result.saturated  = stage_data[hpe_pkg::NUM_STEPS].sat;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Horner polynomial evaluator. A directed table
// covers reset values, ignored register writes, rounding ties and
// saturation. It is followed by random phases, each with a fresh coefficient
// set. Untyped table rows and all random items are compared against a
// predictor that evaluates the polynomial in 64-bit signed arithmetic.
// ----------------------------------------------------------------------------
module testbench;

    typedef hpe_pkg::word_t word_t;

    localparam int CLK_PERIOD   = 8;
    localparam int PIPE_LATENCY = 15;
    localparam int STALL_LIMIT  = 1000;
    localparam int IDLE_PCT     = 16;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 82;

    localparam longint ROUND_HALF = 64'sd1 <<< (hpe_pkg::FRAC_BITS - 1);
    localparam longint WORD_HI    = 64'sd2147483647;
    localparam longint WORD_LO    = -64'sd2147483648;

    localparam word_t SAT_MAX   = hpe_pkg::SAT_MAX;
    localparam word_t SAT_MIN   = hpe_pkg::SAT_MIN;
    localparam word_t Q_ONE     = 32'h0001_0000;
    localparam word_t Q_NEG_ONE = 32'hFFFF_0000;
    localparam word_t Q_HALF    = 32'h0000_8000;

    // Register map of the configuration channel.
    typedef enum logic [hpe_pkg::CFG_IDX_W-1:0] {
        REG_COEFF_0  = 4'd0,
        REG_COEFF_1  = 4'd1,
        REG_COEFF_2  = 4'd2,
        REG_COEFF_3  = 4'd3,
        REG_COEFF_4  = 4'd4,
        REG_COEFF_5  = 4'd5,
        REG_COEFF_6  = 4'd6,
        REG_COEFF_7  = 4'd7,
        REG_SPARE_LO = 4'd8,
        REG_SPARE_HI = 4'd15
    } cfg_reg_e;

    typedef struct packed {
        word_t poly_value;
        logic  saturated;
    } poly_result_t;

    // One row of the directed table: a register write or an argument.
    typedef struct packed {
        logic                          is_write;
        logic [hpe_pkg::CFG_IDX_W-1:0] index;
        word_t                         data;
        logic                          typed;
        word_t                         exp_value;
        logic                          exp_sat;
    } stim_row_t;

    localparam logic ITEM      = 1'b0;
    localparam logic WRITE     = 1'b1;
    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    localparam int DIRECTED_ROWS = 53;

    // Item rows carry the argument in the data column; their index is unused.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // Coefficients are zero after reset.
        '{ITEM,  REG_COEFF_0, SAT_MAX,        TYPED,     32'h0000_0000, 1'b0},
        '{ITEM,  REG_COEFF_0, SAT_MIN,        TYPED,     32'h0000_0000, 1'b0},
        // A constant polynomial.
        '{WRITE, REG_COEFF_0, 32'h1234_5678,  PREDICTED, 32'h0000_0000, 1'b0},
        '{ITEM,  REG_COEFF_0, 32'h0003_8000,  TYPED,     32'h1234_5678, 1'b0},
        // Writes beyond the register list change nothing.
        '{WRITE, REG_SPARE_LO, 32'hDEAD_BEEF, PREDICTED, 32'h0000_0000, 1'b0},
        '{WRITE, REG_SPARE_HI, 32'hFFFF_FFFF, PREDICTED, 32'h0000_0000, 1'b0},
        '{ITEM,  REG_COEFF_0, SAT_MIN,        TYPED,     32'h1234_5678, 1'b0},
        // Identity: p(x) = x.
        '{WRITE, REG_COEFF_0, 32'h0000_0000,  PREDICTED, 32'h0000_0000, 1'b0},
        '{WRITE, REG_COEFF_1, Q_ONE,          PREDICTED, 32'h0000_0000, 1'b0},
        '{ITEM,  REG_COEFF_0, SAT_MAX,        TYPED,     SAT_MAX,       1'b0},
        '{ITEM,  REG_COEFF_0, SAT_MIN,        TYPED,     SAT_MIN,       1'b0},
        '{ITEM,  REG_COEFF_0, 32'h0000_0000,  TYPED,     32'h0000_0000, 1'b0},
        // p(x) = x/2: ties round toward plus infinity.
        '{WRITE, REG_COEFF_1, Q_HALF,         PREDICTED, 32'h0000_0000, 1'b0},
        '{ITEM,  REG_COEFF_0, 32'h0000_0001,  TYPED,     32'h0000_0001, 1'b0},
        '{ITEM,  REG_COEFF_0, 32'hFFFF_FFFF,  TYPED,     32'h0000_0000, 1'b0},
        '{ITEM,  REG_COEFF_0, 32'h0000_0003,  TYPED,     32'h0000_0002, 1'b0},
        // Product overflow in both directions.
        '{WRITE, REG_COEFF_1, SAT_MAX,        PREDICTED, 32'h0000_0000, 1'b0},
        '{ITEM,  REG_COEFF_0, SAT_MAX,        TYPED,     SAT_MAX,       1'b1},
        '{ITEM,  REG_COEFF_0, SAT_MIN,        TYPED,     SAT_MIN,       1'b1},
        // Overflow caused by the coefficient addition alone.
        '{WRITE, REG_COEFF_1, Q_ONE,          PREDICTED, 32'h0000_0000, 1'b0},
        '{WRITE, REG_COEFF_0, SAT_MAX,        PREDICTED, 32'h0000_0000, 1'b0},
        '{ITEM,  REG_COEFF_0, Q_ONE,          TYPED,     SAT_MAX,       1'b1},
        '{ITEM,  REG_COEFF_0, Q_NEG_ONE,      TYPED,     32'h7FFE_FFFF, 1'b0},
        '{WRITE, REG_COEFF_0, SAT_MIN,        PREDICTED, 32'h0000_0000, 1'b0},
        '{ITEM,  REG_COEFF_0, Q_NEG_ONE,      TYPED,     SAT_MIN,       1'b1},
        '{ITEM,  REG_COEFF_0, Q_ONE,          TYPED,     32'h8001_0000, 1'b0},
        // A saturated step followed by one that brings the value back.
        '{WRITE, REG_COEFF_2, SAT_MAX,        PREDICTED, 32'h0000_0000, 1'b0},
        '{WRITE, REG_COEFF_1, 32'h0000_0001,  PREDICTED, 32'h0000_0000, 1'b0},
        '{ITEM,  REG_COEFF_0, Q_ONE,          PREDICTED, 32'h0000_0000, 1'b0},
        // Every coefficient at the positive extreme.
        '{WRITE, REG_COEFF_0, SAT_MAX,        PREDICTED, 32'h0000_0000, 1'b0},
        '{WRITE, REG_COEFF_1, SAT_MAX,        PREDICTED, 32'h0000_0000, 1'b0},
        '{WRITE, REG_COEFF_2, SAT_MAX,        PREDICTED, 32'h0000_0000, 1'b0},
        '{WRITE, REG_COEFF_3, SAT_MAX,        PREDICTED, 32'h0000_0000, 1'b0},
        '{WRITE, REG_COEFF_4, SAT_MAX,        PREDICTED, 32'h0000_0000, 1'b0},
        '{WRITE, REG_COEFF_5, SAT_MAX,        PREDICTED, 32'h0000_0000, 1'b0},
        '{WRITE, REG_COEFF_6, SAT_MAX,        PREDICTED, 32'h0000_0000, 1'b0},
        '{WRITE, REG_COEFF_7, SAT_MAX,        PREDICTED, 32'h0000_0000, 1'b0},
        '{ITEM,  REG_COEFF_0, SAT_MAX,        PREDICTED, 32'h0000_0000, 1'b0},
        '{ITEM,  REG_COEFF_0, SAT_MIN,        PREDICTED, 32'h0000_0000, 1'b0},
        '{ITEM,  REG_COEFF_0, Q_ONE,          PREDICTED, 32'h0000_0000, 1'b0},
        '{ITEM,  REG_COEFF_0, 32'h0000_0000,  TYPED,     SAT_MAX,       1'b0},
        // Every coefficient at the negative extreme.
        '{WRITE, REG_COEFF_0, SAT_MIN,        PREDICTED, 32'h0000_0000, 1'b0},
        '{WRITE, REG_COEFF_1, SAT_MIN,        PREDICTED, 32'h0000_0000, 1'b0},
        '{WRITE, REG_COEFF_2, SAT_MIN,        PREDICTED, 32'h0000_0000, 1'b0},
        '{WRITE, REG_COEFF_3, SAT_MIN,        PREDICTED, 32'h0000_0000, 1'b0},
        '{WRITE, REG_COEFF_4, SAT_MIN,        PREDICTED, 32'h0000_0000, 1'b0},
        '{WRITE, REG_COEFF_5, SAT_MIN,        PREDICTED, 32'h0000_0000, 1'b0},
        '{WRITE, REG_COEFF_6, SAT_MIN,        PREDICTED, 32'h0000_0000, 1'b0},
        '{WRITE, REG_COEFF_7, SAT_MIN,        PREDICTED, 32'h0000_0000, 1'b0},
        '{ITEM,  REG_COEFF_0, SAT_MAX,        PREDICTED, 32'h0000_0000, 1'b0},
        '{ITEM,  REG_COEFF_0, SAT_MIN,        PREDICTED, 32'h0000_0000, 1'b0},
        '{ITEM,  REG_COEFF_0, Q_NEG_ONE,      PREDICTED, 32'h0000_0000, 1'b0},
        '{ITEM,  REG_COEFF_0, Q_HALF,         PREDICTED, 32'h0000_0000, 1'b0}
    };

    logic clk = 1'b0;
    logic rst_n;

    hpe_arg_if arg_if ();
    hpe_res_if res_if ();
    hpe_cfg_if cfg_if ();

    horner_polynomial_eval uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .arg    (arg_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    word_t        coeff_shadow [hpe_pkg::REG_COUNT];
    poly_result_t expected_polys [$];
    int           mismatch_count = 0;
    int           quiet_cycles   = 0;
    int           idle_pct       = IDLE_PCT;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Horner evaluation with the full-width product, round half up and
    // saturation after every step.
    function automatic poly_result_t horner_eval(input word_t x);
        longint       xs;
        longint       acc;
        longint       prod;
        longint       cval;
        poly_result_t res;
        xs = $signed(x);
        acc = 0;
        res.saturated = 1'b0;
        for (int i = hpe_pkg::NUM_COEFFS - 1; i >= 0; i--)
        begin
            cval = $signed(coeff_shadow[i]);
            prod = acc * xs;
            acc = ((prod + ROUND_HALF) >>> hpe_pkg::FRAC_BITS) + cval;
            if (acc > WORD_HI)
            begin
                acc = WORD_HI;
                res.saturated = 1'b1;
            end
            else if (acc < WORD_LO)
            begin
                acc = WORD_LO;
                res.saturated = 1'b1;
            end
        end
        res.poly_value = word_t'(acc);
        return res;
    endfunction

    function automatic word_t corner_word();
        case ($urandom_range(4))
            0:       return SAT_MAX;
            1:       return SAT_MIN;
            2:       return Q_ONE;
            3:       return Q_NEG_ONE;
            default: return '0;
        endcase
    endfunction

    // Arguments: mostly near the unit range, with full-range and corner values.
    function automatic word_t pick_arg();
        word_t r;
        r = $urandom;
        case ($urandom_range(9))
            0, 1:    return r;
            2:       return corner_word();
            3:       return {{28{r[3]}}, r[3:0]};
            default: return {{14{r[17]}}, r[17:0]};
        endcase
    endfunction

    // Style 0 keeps coefficients within about +/-4.0, style 1 is full range,
    // style 2 mixes extremes with random words.
    function automatic word_t pick_coeff(input int style);
        word_t r;
        r = $urandom;
        case (style)
            0:       return {{13{r[18]}}, r[18:0]};
            1:       return r;
            default: return ($urandom_range(1) != 0) ? corner_word() : r;
        endcase
    endfunction

    // Present one argument; valid stays high after the transaction so that
    // back-to-back arguments need no extra edge.
    task automatic send_arg(input word_t x, input poly_result_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            arg_if.valid <= 1'b0;
            @(posedge clk);
        end
        arg_if.valid   <= 1'b1;
        arg_if.x_value <= x;
        @(posedge clk);
        while (!arg_if.ready)
            @(posedge clk);
        expected_polys.push_back(want);
    endtask

    // Stop sending and wait until every outstanding result has come back.
    task automatic drain_results();
        arg_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_polys.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [hpe_pkg::CFG_IDX_W-1:0] idx, input word_t value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        if (idx < hpe_pkg::REG_COUNT)
            coeff_shadow[idx[hpe_pkg::COEFF_IDX_W-1:0]] = value;
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Result side: random backpressure and in-order comparison.
    always @(posedge clk)
    begin
        poly_result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (expected_polys.size() == 0)
            begin
                $error("unexpected result transaction: poly_value %h saturated %b",
                       res_if.poly_value, res_if.saturated);
                mismatch_count++;
            end
            else
            begin
                want = expected_polys.pop_front();
                if (res_if.poly_value !== want.poly_value)
                begin
                    $error("poly_value: expected %h, actual %h",
                           want.poly_value, res_if.poly_value);
                    mismatch_count++;
                end
                if (res_if.saturated !== want.saturated)
                begin
                    $error("saturated: expected %b, actual %b",
                           want.saturated, res_if.saturated);
                    mismatch_count++;
                end
            end
        end
        res_if.ready <= ($urandom_range(99) >= idle_pct);
    end

    // Watchdog: too long without any transaction on any channel.
    always @(posedge clk)
    begin
        if ((arg_if.valid && arg_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL horner_polynomial_eval");
            $finish;
        end
    end

    // Stimulus: reset, directed table, then random phases.
    initial
    begin
        stim_row_t    row;
        poly_result_t want;
        word_t        x;
        bit           settled;
        int           style;
        int           top;
        int           rot;
        int           slot;

        rst_n          = 1'b0;
        arg_if.valid   = 1'b0;
        arg_if.x_value = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = '0;
        cfg_if.data    = '0;
        for (int k = 0; k < hpe_pkg::REG_COUNT; k++)
            coeff_shadow[k] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; writes wait until the pipeline is empty.
        settled = 1'b1;
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            row = directed_rows[r];
            if (row.is_write)
            begin
                if (!settled)
                    drain_results();
                settled = 1'b1;
                write_reg(row.index, row.data);
            end
            else
            begin
                settled = 1'b0;
                if (row.typed)
                begin
                    want.poly_value = row.exp_value;
                    want.saturated  = row.exp_sat;
                end
                else
                    want = horner_eval(row.data);
                send_arg(row.data, want);
            end
        end

        // Random phases, each with its own coefficient set and degree.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            drain_results();
            idle_pct = (phase == 3) ? 0 : IDLE_PCT;
            style = phase % 3;
            top = ($urandom_range(1) != 0) ? $urandom_range(hpe_pkg::NUM_COEFFS - 1)
                                           : hpe_pkg::NUM_COEFFS - 1;
            rot = $urandom_range(hpe_pkg::REG_COUNT - 1);
            for (int k = 0; k < hpe_pkg::REG_COUNT; k++)
            begin
                slot = (k + rot) % hpe_pkg::REG_COUNT;
                write_reg(hpe_pkg::CFG_IDX_W'(REG_COEFF_0 + slot),
                          (slot <= top) ? pick_coeff(style) : '0);
            end
            if ($urandom_range(1) != 0)
                write_reg(hpe_pkg::CFG_IDX_W'(REG_SPARE_LO + $urandom_range(7)), $urandom);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Let the pipeline run dry once in the middle of a phase.
                if (phase == 1 && n == PHASE_ITEMS / 2)
                    drain_results();
                x = pick_arg();
                send_arg(x, horner_eval(x));
            end
        end

        drain_results();
        repeat (2 * PIPE_LATENCY) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS horner_polynomial_eval");
        else
            $display("FAIL horner_polynomial_eval");
        $finish;
    end

endmodule
